>>> hw/rtl/kce_pkg.sv
`default_nettype none
package kce_pkg;

   // Default sizing
   localparam int MAX_KEYS_DEF  = 256;
   localparam int FRAC_BITS_DEF = 16;

   // Fixed field widths
   localparam int DATA_W     = 32;
   localparam int KIDX_W     = 8;
   localparam int KCNT_W     = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   // Item kinds and result status codes
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_EVAL    = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERP_MODE = 1'b0,
      CSR_KEY_COUNT   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                     kind;
      logic [KIDX_W-1:0]        key_index;
      logic signed [DATA_W-1:0] key_time;
      logic signed [DATA_W-1:0] key_value;
      logic signed [DATA_W-1:0] key_in_slope;
      logic signed [DATA_W-1:0] key_out_slope;
      logic signed [DATA_W-1:0] eval_time;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] curve_value;
      logic                     status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_RD0, S_CHK0, S_RDN, S_CHKN, S_SRCH, S_SCMP, S_LDL, S_LDR,
      S_DIV, S_MLIN, S_LEND, S_MT2, S_MT3, S_MDL, S_MDR, S_MA, S_MB, S_MC,
      S_MD, S_MEND, S_FIN
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_TT, MUL_T2T, MUL_OUTDT, MUL_INDT, MUL_AV, MUL_BD,
      MUL_CD, MUL_DV, MUL_LIN
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_LIN
   } acc_op_type;

   typedef enum logic [1:0] {
      RES_EMPTY, RES_RDVAL, RES_ACC
   } res_sel_type;

   typedef struct packed {
      logic              key_wr;
      logic              time_take;
      logic              rd_en;
      logic [KCNT_W-1:0] rd_idx;
      logic              take_left;
      logic              take_right;
      logic              div_step;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
      logic              rsp_load;
      res_sel_type       res_sel;
   } cmd_type;

   typedef struct packed {
      logic time_lt;
      logic time_gt;
   } sts_type;

endpackage
`default_nettype wire

>>> hw/rtl/kce_ctrl.sv
`default_nettype none
module kce_ctrl #(
   parameter int MAX_KEYS  = kce_pkg::MAX_KEYS_DEF,
   parameter int FRAC_BITS = kce_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_kind,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire kce_pkg::csr_index_type            csr_index,
   input  wire logic [kce_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output kce_pkg::cmd_type                       cmd,
   input  wire kce_pkg::sts_type                  sts
);
   import kce_pkg::*;

   localparam int CNTW = $clog2(FRAC_BITS + 1);

   state_type         state_ff, state_in;
   logic [KCNT_W-1:0] l_ff, l_in, r_ff, r_in, m_ff, m_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   res_sel_type       res_sel_ff, res_sel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              mode_ff;
   logic [KCNT_W-1:0] count_ff;
   logic [KCNT_W-1:0] n_w;
   logic [KCNT_W:0]   lr_sum;
   logic [KCNT_W-1:0] mid_w;
   logic              more_w;

   // Keys in use, limited to the table depth
   assign n_w    = (32'(count_ff) > 32'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : count_ff;
   assign lr_sum = {1'b0, l_ff} + {1'b0, r_ff};
   assign mid_w  = lr_sum[KCNT_W:1];
   assign more_w = ({1'b0, l_ff} + (KCNT_W+1)'(1)) < {1'b0, r_ff};

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in   = state_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      m_in       = m_ff;
      cnt_in     = cnt_ff;
      res_sel_in = res_sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_kind == KIND_EVAL) begin
               if (n_w == '0) begin
                  res_sel_in = RES_EMPTY;
                  state_in   = S_FIN;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_RD0: state_in = S_CHK0;
         S_CHK0: begin
            if (n_w == KCNT_W'(1) || !sts.time_lt) begin
               res_sel_in = RES_RDVAL;
               state_in   = S_FIN;
            end else begin
               state_in = S_RDN;
            end
         end
         S_RDN: state_in = S_CHKN;
         S_CHKN: begin
            if (!sts.time_gt) begin
               res_sel_in = RES_RDVAL;
               state_in   = S_FIN;
            end else begin
               l_in     = '0;
               r_in     = n_w - KCNT_W'(1);
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (more_w) begin
               m_in     = mid_w;
               state_in = S_SCMP;
            end else begin
               state_in = S_LDL;
            end
         end
         S_SCMP: begin
            if (sts.time_lt) begin
               l_in = m_ff;
            end else begin
               r_in = m_ff;
            end
            state_in = S_SRCH;
         end
         S_LDL: state_in = S_LDR;
         S_LDR: begin
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(FRAC_BITS)) begin
               state_in = mode_ff ? S_MT2 : S_MLIN;
            end
         end
         S_MLIN: state_in = S_LEND;
         S_LEND: begin
            res_sel_in = RES_ACC;
            state_in   = S_FIN;
         end
         S_MT2:  state_in = S_MT3;
         S_MT3:  state_in = S_MDL;
         S_MDL:  state_in = S_MDR;
         S_MDR:  state_in = S_MA;
         S_MA:   state_in = S_MB;
         S_MB:   state_in = S_MC;
         S_MC:   state_in = S_MD;
         S_MD:   state_in = S_MEND;
         S_MEND: begin
            res_sel_in = RES_ACC;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result word until the receiver takes it
   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (state_ff == S_FIN);

   // Outputs
   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      cmd            = '0;
      cmd.mul_sel    = MUL_NONE;
      cmd.acc_op     = ACC_HOLD;
      cmd.res_sel    = res_sel_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.key_wr    = req_valid && req_kind == KIND_LOAD;
            cmd.time_take = req_valid && req_kind == KIND_EVAL;
         end
         S_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = '0;
         end
         S_RDN: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = n_w - KCNT_W'(1);
         end
         S_SRCH: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = more_w ? mid_w : l_ff;
         end
         S_LDL: begin
            cmd.take_left = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_idx    = r_ff;
         end
         S_LDR:  cmd.take_right = 1'b1;
         S_DIV:  cmd.div_step = 1'b1;
         S_MLIN: cmd.mul_sel = MUL_LIN;
         S_LEND: cmd.acc_op = ACC_LIN;
         S_MT2:  cmd.mul_sel = MUL_TT;
         S_MT3:  cmd.mul_sel = MUL_T2T;
         S_MDL:  cmd.mul_sel = MUL_OUTDT;
         S_MDR:  cmd.mul_sel = MUL_INDT;
         S_MA:   cmd.mul_sel = MUL_AV;
         S_MB: begin
            cmd.mul_sel = MUL_BD;
            cmd.acc_op  = ACC_LOAD;
         end
         S_MC: begin
            cmd.mul_sel = MUL_CD;
            cmd.acc_op  = ACC_ADD;
         end
         S_MD: begin
            cmd.mul_sel = MUL_DV;
            cmd.acc_op  = ACC_ADD;
         end
         S_MEND: cmd.acc_op = ACC_ADD;
         S_FIN:  cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         default: cmd.rsp_load = 1'b0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         res_sel_ff   <= RES_EMPTY;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         res_sel_ff   <= res_sel_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_INTERP_MODE: mode_ff <= csr_wdata[0];
               CSR_KEY_COUNT:   count_ff <= csr_wdata;
               default:         mode_ff <= mode_ff;
            endcase
         end
      end
   end

   // Search bounds and step counter
   always_ff @(posedge clock) begin
      l_ff   <= l_in;
      r_ff   <= r_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/kce_datapath.sv
`default_nettype none
module kce_datapath #(
   parameter int MAX_KEYS  = kce_pkg::MAX_KEYS_DEF,
   parameter int FRAC_BITS = kce_pkg::FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire kce_pkg::req_type req_data,
   input  wire kce_pkg::cmd_type cmd,
   output kce_pkg::sts_type      sts,
   output kce_pkg::rsp_type      rsp_data
);
   import kce_pkg::*;

   localparam int AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int EW    = 4 * DATA_W;
   localparam int DW    = DATA_W + 1;
   localparam int REMW  = DATA_W + 2;
   localparam int QW    = FRAC_BITS + 1;
   localparam int CW    = FRAC_BITS + 3;
   localparam int XW    = DATA_W + 1;
   localparam int YW    = DATA_W + 5;
   localparam int PW    = XW + YW;
   localparam int ACW   = PW + 2;

   localparam logic signed [PW-1:0]  TAN_HI = PW'(1) <<< 35;
   localparam logic signed [PW-1:0]  TAN_LO = -(PW'(1) <<< 35);
   localparam logic signed [ACW-1:0] SAT_HI = ACW'(32'h7fff_ffff);
   localparam logic signed [ACW-1:0] SAT_LO = -(ACW'(1) <<< (DATA_W - 1));
   localparam logic signed [CW-1:0]  ONE    = CW'(1) <<< FRAC_BITS;

   logic [EW-1:0]            mem_ff [MAX_KEYS];
   logic [EW-1:0]            rd_ff;
   logic signed [DATA_W-1:0] rd_time, rd_value, rd_in, rd_out;
   logic signed [DATA_W-1:0] tm_ff, tl_ff, vl_ff, vr_ff, sl_ff, sr_ff;
   logic signed [DW-1:0]     dt_ff;
   logic [REMW-1:0]          rem_ff;
   logic [QW-1:0]            q_ff, t2_ff, t3_ff;
   logic signed [YW-1:0]     dl_ff, dr_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [ACW-1:0]    acc_ff;
   rsp_type                  rsp_ff;

   logic                     wr_ok;
   logic signed [DW-1:0]     tm_diff, rd_diff, v_diff;
   logic [REMW-1:0]          rem_sub;
   logic                     rem_ge;
   logic [QW-1:0]            t2_w;
   logic signed [CW-1:0]     t2s, t3s, ts, a_w, b_w, c_w, d_w;
   logic signed [XW-1:0]     mul_x;
   logic signed [YW-1:0]     mul_y;
   logic signed [PW-1:0]     prod_sh;
   logic signed [YW-1:0]     tan_w;
   logic signed [ACW-1:0]    prod_ext, res_sh;
   logic signed [DATA_W-1:0] sat_w;

   assign rd_time  = rd_ff[EW-1 -: DATA_W];
   assign rd_value = rd_ff[3*DATA_W-1 -: DATA_W];
   assign rd_in    = rd_ff[2*DATA_W-1 -: DATA_W];
   assign rd_out   = rd_ff[DATA_W-1:0];

   assign sts.time_lt = rd_time < tm_ff;
   assign sts.time_gt = rd_time > tm_ff;

   // Key table: one write port for loads, one registered read port
   assign wr_ok = {{(32-KIDX_W){1'b0}}, req_data.key_index} < 32'(MAX_KEYS);

   always_ff @(posedge clock) begin
      if (cmd.key_wr && wr_ok) begin
         mem_ff[AW'(req_data.key_index)] <= {req_data.key_time, req_data.key_value,
                                             req_data.key_in_slope, req_data.key_out_slope};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[AW'(cmd.rd_idx)];
      end
   end

   // Interval and offset, both positive inside the bracket
   assign tm_diff = {tm_ff[DATA_W-1], tm_ff} - {tl_ff[DATA_W-1], tl_ff};
   assign rd_diff = {rd_time[DATA_W-1], rd_time} - {tl_ff[DATA_W-1], tl_ff};
   assign v_diff  = {vr_ff[DATA_W-1], vr_ff} - {vl_ff[DATA_W-1], vl_ff};

   // Restoring divider, one quotient bit a step
   assign rem_sub = rem_ff - {1'b0, dt_ff};
   assign rem_ge  = rem_ff >= {1'b0, dt_ff};

   // Hermite basis weights
   assign t2_w = prod_ff[FRAC_BITS +: QW];
   assign t2s  = {2'b00, t2_ff};
   assign t3s  = {2'b00, t3_ff};
   assign ts   = {2'b00, q_ff};
   assign a_w  = (t3s <<< 1) - (t2s + (t2s <<< 1)) + ONE;
   assign b_w  = t3s - (t2s <<< 1) + ts;
   assign c_w  = t3s - t2s;
   assign d_w  = (t2s + (t2s <<< 1)) - (t3s <<< 1);

   // Operand select for the shared multiplier
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (cmd.mul_sel)
         MUL_TT: begin
            mul_x = XW'(q_ff);
            mul_y = YW'(q_ff);
         end
         MUL_T2T: begin
            mul_x = XW'(t2_w);
            mul_y = YW'(q_ff);
         end
         MUL_OUTDT: begin
            mul_x = XW'(sl_ff);
            mul_y = YW'(dt_ff);
         end
         MUL_INDT: begin
            mul_x = XW'(sr_ff);
            mul_y = YW'(dt_ff);
         end
         MUL_AV: begin
            mul_x = XW'(a_w);
            mul_y = YW'(vl_ff);
         end
         MUL_BD: begin
            mul_x = XW'(b_w);
            mul_y = dl_ff;
         end
         MUL_CD: begin
            mul_x = XW'(c_w);
            mul_y = dr_ff;
         end
         MUL_DV: begin
            mul_x = XW'(d_w);
            mul_y = YW'(vr_ff);
         end
         MUL_LIN: begin
            mul_x = XW'(q_ff);
            mul_y = YW'(v_diff);
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   // Scaled tangent, limited to the tangent range
   assign prod_sh = prod_ff >>> FRAC_BITS;
   always_comb begin
      if (prod_sh > TAN_HI) begin
         tan_w = YW'(TAN_HI);
      end else if (prod_sh < TAN_LO) begin
         tan_w = YW'(TAN_LO);
      end else begin
         tan_w = YW'(prod_sh);
      end
   end

   // Final shift and saturation to the output width
   assign prod_ext = ACW'(prod_ff);
   assign res_sh   = acc_ff >>> FRAC_BITS;
   always_comb begin
      if (res_sh > SAT_HI) begin
         sat_w = DATA_W'(SAT_HI);
      end else if (res_sh < SAT_LO) begin
         sat_w = DATA_W'(SAT_LO);
      end else begin
         sat_w = DATA_W'(res_sh);
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.time_take) begin
         tm_ff <= req_data.eval_time;
      end
      if (cmd.take_left) begin
         tl_ff <= rd_time;
         vl_ff <= rd_value;
         sl_ff <= rd_out;
      end
      if (cmd.take_right) begin
         vr_ff  <= rd_value;
         sr_ff  <= rd_in;
         dt_ff  <= rd_diff;
         rem_ff <= {1'b0, tm_diff};
         q_ff   <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= {(rem_ge ? rem_sub[REMW-2:0] : rem_ff[REMW-2:0]), 1'b0};
         q_ff   <= {q_ff[QW-2:0], rem_ge};
      end
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= PW'(mul_x * mul_y);
      end
      if (cmd.mul_sel == MUL_T2T) begin
         t2_ff <= t2_w;
      end
      if (cmd.mul_sel == MUL_OUTDT) begin
         t3_ff <= t2_w;
      end
      if (cmd.mul_sel == MUL_INDT) begin
         dl_ff <= tan_w;
      end
      if (cmd.mul_sel == MUL_AV) begin
         dr_ff <= tan_w;
      end
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= prod_ext;
         ACC_ADD:  acc_ff <= acc_ff + prod_ext;
         ACC_LIN:  acc_ff <= (ACW'(vl_ff) <<< FRAC_BITS) + prod_ext;
         default:  acc_ff <= acc_ff;
      endcase
      if (cmd.rsp_load) begin
         case (cmd.res_sel)
            RES_RDVAL: begin
               rsp_ff.curve_value <= rd_value;
               rsp_ff.status      <= STATUS_OK;
            end
            RES_ACC: begin
               rsp_ff.curve_value <= sat_w;
               rsp_ff.status      <= STATUS_OK;
            end
            default: begin
               rsp_ff.curve_value <= '0;
               rsp_ff.status      <= STATUS_EMPTY;
            end
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

>>> hw/rtl/keyframe_curve_evaluator_core.sv
// Keyframe curve evaluator: table of up to MAX_KEYS keys (time, value,
// in-slope, out-slope, signed fixed point), evaluated by linear or cubic
// Hermite interpolation.
// req channel: a load word writes one key in the cycle it is taken and gives
// no result; an evaluate word gives exactly one rsp word.
// csr channel: always ready; index 0 interp_mode, index 1 key_count. Write
// only while no evaluation is in flight.
// Evaluate: an empty table gives the empty status without reading the table;
//   a time at or beyond an end key gives that key's value; otherwise a binary
//   search finds the bracketing keys, each probe a read on the single
//   registered table read port, then the restoring divider forms the fraction,
//   and for Hermite the terms go one by one through a single shared
//   multiplier.
// One item is worked at a time; req_ready is high whenever the block is
// idle, also while an earlier result word still waits in the output register.
// If rsp_ready stays low, a further finished result waits and req_ready stays low.
// Reset clears the control registers to mode linear and zero keys; table
// contents are undefined until loaded.
`default_nettype none
module keyframe_curve_evaluator_core #(
   parameter int MAX_KEYS  = kce_pkg::MAX_KEYS_DEF,
   parameter int FRAC_BITS = kce_pkg::FRAC_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire kce_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output kce_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire kce_pkg::csr_index_type         csr_index,
   input  wire logic [kce_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import kce_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   kce_ctrl #(
      .MAX_KEYS  (MAX_KEYS),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_data.kind),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Key table and arithmetic
   kce_datapath #(
      .MAX_KEYS  (MAX_KEYS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
